>>> rtl/bnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bnm_pkg;

	localparam int PROG_SIZE   = 4096;
	localparam int BLOCK_DEPTH = 32;
	localparam int SCOPE_DEPTH = 32;
	localparam int NUM_VARS    = 64;

	localparam int POS_W  = 12;
	localparam int CNT_W  = 13;
	localparam int VAR_W  = 6;
	localparam int BLK_AW = $clog2(BLOCK_DEPTH);
	localparam int BLK_DW = $clog2(BLOCK_DEPTH + 1);
	localparam int SCP_AW = $clog2(SCOPE_DEPTH);
	localparam int SCP_DW = $clog2(SCOPE_DEPTH + 1);
	localparam int BLK_EW = POS_W + 2;
	localparam int SCP_EW = POS_W + VAR_W;

	localparam logic [3:0] ACT_SET     = 4'd0;
	localparam logic [3:0] ACT_ARITH   = 4'd1;
	localparam logic [3:0] ACT_GOTO    = 4'd2;
	localparam logic [3:0] ACT_IFGR    = 4'd3;
	localparam logic [3:0] ACT_IFEQ    = 4'd4;
	localparam logic [3:0] ACT_ELSE    = 4'd5;
	localparam logic [3:0] ACT_ENDIF   = 4'd6;
	localparam logic [3:0] ACT_LOOP    = 4'd7;
	localparam logic [3:0] ACT_ENDLOOP = 4'd8;

	localparam logic [1:0] K_ACC   = 2'd0;
	localparam logic [1:0] K_PATCH = 2'd1;
	localparam logic [1:0] K_SCOPE = 2'd2;
	localparam logic [1:0] K_ERR   = 2'd3;

	localparam logic [1:0] OP_IFGR = 2'd0;
	localparam logic [1:0] OP_IFEQ = 2'd1;
	localparam logic [1:0] OP_ELSE = 2'd2;
	localparam logic [1:0] OP_LOOP = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_OPERAND  = 3'd1;
	localparam logic [2:0] ERR_GOTO0    = 3'd2;
	localparam logic [2:0] ERR_LOOPCNT  = 3'd3;
	localparam logic [2:0] ERR_ELSE     = 3'd4;
	localparam logic [2:0] ERR_ENDIF    = 3'd5;
	localparam logic [2:0] ERR_ENDLOOP  = 3'd6;
	localparam logic [2:0] ERR_FULL     = 3'd7;

	typedef struct packed {
		logic       latch_in;
		logic       emit;
		logic [1:0] emit_kind;
		logic       commit;
		logic       scope_pop;
	} cmd_t;

	typedef struct packed {
		logic       ignore;
		logic       is_closer;
		logic [2:0] err;
		logic       scope_more;
		logic       emit_ok;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/bnm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/bnm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bnm_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bnm_pkg::cmd_t       cmd,
	output bnm_pkg::sts_t            sts,
	input  wire logic [3:0]          action,
	input  wire logic                operand_ok,
	input  wire logic [5:0]          target_var,
	input  wire logic                has_count,
	input  wire logic signed [31:0]  const_value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               kind,
	output logic [11:0]              first_pos,
	output logic [12:0]              second_pos,
	output logic [1:0]               opener_kind,
	output logic [2:0]               error_code,
	output logic                     last
);
	import bnm_pkg::*;

	logic [3:0]        action_q;
	logic              ok_q;
	logic [VAR_W-1:0]  tv_q;
	logic              has_count_q;
	logic [31:0]       cv_q;
	logic [CNT_W-1:0]  instr_q;
	logic [BLK_DW-1:0] blk_depth_q;
	logic [SCP_DW-1:0] scp_depth_q;
	logic [NUM_VARS-1:0] var_active_q;

	logic              blk_we;
	logic [BLK_AW-1:0] blk_waddr;
	logic [BLK_EW-1:0] blk_wdata;
	logic [BLK_AW-1:0] blk_raddr;
	logic [BLK_EW-1:0] blk_rdata;
	logic              scp_we;
	logic [SCP_AW-1:0] scp_raddr;
	logic [SCP_EW-1:0] scp_rdata;

	logic [POS_W-1:0]  top_pos;
	logic [1:0]        top_kind;
	logic [POS_W-1:0]  scp_pos;
	logic [VAR_W-1:0]  scp_var;
	logic              full;
	logic              blk_full;
	logic              scp_full;
	logic              blk_empty;
	logic              tv_bad;
	logic              tv_active;
	logic              cv_zero;
	logic              is_opener;
	logic              push_scope;
	logic [1:0]        new_kind;
	logic [2:0]        err;
	logic [2:0]        close_code;
	logic              match;
	logic [CNT_W-1:0]  scope_end;

	assign blk_raddr = BLK_AW'(blk_depth_q - BLK_DW'(1));
	assign scp_raddr = SCP_AW'(scp_depth_q - SCP_DW'(1));
	assign top_pos   = blk_rdata[BLK_EW-1:2];
	assign top_kind  = blk_rdata[1:0];
	assign scp_pos   = scp_rdata[SCP_EW-1:VAR_W];
	assign scp_var   = scp_rdata[VAR_W-1:0];

	assign full      = instr_q >= CNT_W'(PROG_SIZE);
	assign blk_full  = blk_depth_q >= BLK_DW'(BLOCK_DEPTH);
	assign scp_full  = scp_depth_q >= SCP_DW'(SCOPE_DEPTH);
	assign blk_empty = blk_depth_q == '0;
	assign tv_bad    = int'(tv_q) >= NUM_VARS;
	assign tv_active = var_active_q[tv_q];
	assign cv_zero   = cv_q == '0;
	assign scope_end = (action_q == ACT_ENDIF) ? instr_q : instr_q + CNT_W'(1);

	always_comb begin
		is_opener = 1'b0;
		new_kind  = OP_LOOP;
		match     = 1'b0;
		err       = ERR_NONE;
		close_code = ERR_ENDLOOP;
		case (action_q)
			ACT_SET: begin
				if (!ok_q || tv_bad) begin
					err = ERR_OPERAND;
				end else if (full || (!tv_active && scp_full)) begin
					err = ERR_FULL;
				end
			end
			ACT_ARITH: begin
				if (!ok_q) begin
					err = ERR_OPERAND;
				end else if (full) begin
					err = ERR_FULL;
				end
			end
			ACT_GOTO: begin
				if (!ok_q) begin
					err = ERR_OPERAND;
				end else if (cv_zero) begin
					err = ERR_GOTO0;
				end else if (full) begin
					err = ERR_FULL;
				end
			end
			ACT_IFGR, ACT_IFEQ: begin
				is_opener = 1'b1;
				new_kind  = (action_q == ACT_IFGR) ? OP_IFGR : OP_IFEQ;
				if (!ok_q) begin
					err = ERR_OPERAND;
				end else if (full || blk_full) begin
					err = ERR_FULL;
				end
			end
			ACT_LOOP: begin
				is_opener = 1'b1;
				if (has_count_q && !ok_q) begin
					err = ERR_OPERAND;
				end else if (has_count_q && (cv_zero || cv_q[31])) begin
					err = ERR_LOOPCNT;
				end else if (full || blk_full) begin
					err = ERR_FULL;
				end
			end
			ACT_ELSE, ACT_ENDIF, ACT_ENDLOOP: begin
				if (action_q == ACT_ELSE) begin
					close_code = ERR_ELSE;
					match = (top_kind == OP_IFGR) || (top_kind == OP_IFEQ);
				end else if (action_q == ACT_ENDIF) begin
					close_code = ERR_ENDIF;
					match = top_kind != OP_LOOP;
				end else begin
					match = top_kind == OP_LOOP;
				end
				if (blk_empty || !match) begin
					err = close_code;
				end else if (full) begin
					err = ERR_FULL;
				end
			end
			default: begin
				err = ERR_NONE;
			end
		endcase
	end

	always_comb begin
		sts.ignore     = action_q > ACT_ENDLOOP;
		sts.is_closer  = action_q inside {ACT_ELSE, ACT_ENDIF, ACT_ENDLOOP};
		sts.err        = err;
		sts.scope_more = (scp_depth_q != '0) && (scp_pos > top_pos);
		sts.emit_ok    = !out_valid || !out_stall;
	end

	assign push_scope = cmd.commit && (action_q == ACT_SET) && !tv_active;
	assign blk_we     = cmd.commit && (is_opener || action_q == ACT_ELSE);
	assign blk_waddr  = (action_q == ACT_ELSE) ? blk_raddr : BLK_AW'(blk_depth_q);
	assign blk_wdata  = (action_q == ACT_ELSE) ? {instr_q[POS_W-1:0], OP_ELSE}
	                                           : {instr_q[POS_W-1:0], new_kind};
	assign scp_we     = push_scope;

	bnm_ram #(.WIDTH(BLK_EW), .DEPTH(BLOCK_DEPTH)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (blk_waddr),
		.wdata (blk_wdata),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	bnm_ram #(.WIDTH(SCP_EW), .DEPTH(SCOPE_DEPTH)) u_scp_ram (
		.clk   (clk),
		.we    (scp_we),
		.waddr (SCP_AW'(scp_depth_q)),
		.wdata ({instr_q[POS_W-1:0], tv_q}),
		.raddr (scp_raddr),
		.rdata (scp_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			action_q    <= action;
			ok_q        <= operand_ok;
			tv_q        <= target_var;
			has_count_q <= has_count;
			cv_q        <= const_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr_q      <= '0;
			blk_depth_q  <= '0;
			scp_depth_q  <= '0;
			var_active_q <= '0;
		end else begin
			if (cmd.commit) begin
				instr_q <= instr_q + CNT_W'(1);
				if (is_opener) begin
					blk_depth_q <= blk_depth_q + BLK_DW'(1);
				end else if (action_q == ACT_ENDIF || action_q == ACT_ENDLOOP) begin
					blk_depth_q <= blk_depth_q - BLK_DW'(1);
				end
			end
			if (push_scope) begin
				scp_depth_q          <= scp_depth_q + SCP_DW'(1);
				var_active_q[tv_q]   <= 1'b1;
			end else if (cmd.scope_pop) begin
				scp_depth_q          <= scp_depth_q - SCP_DW'(1);
				var_active_q[scp_var] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind <= cmd.emit_kind;
			case (cmd.emit_kind)
				K_ERR: begin
					first_pos   <= '0;
					second_pos  <= instr_q;
					opener_kind <= OP_IFGR;
					error_code  <= err;
					last        <= 1'b1;
				end
				K_PATCH: begin
					first_pos   <= top_pos;
					second_pos  <= instr_q;
					opener_kind <= top_kind;
					error_code  <= ERR_NONE;
					last        <= 1'b0;
				end
				K_SCOPE: begin
					first_pos   <= scp_pos;
					second_pos  <= scope_end;
					opener_kind <= OP_IFGR;
					error_code  <= ERR_NONE;
					last        <= 1'b0;
				end
				default: begin
					first_pos   <= instr_q[POS_W-1:0];
					second_pos  <= '0;
					opener_kind <= OP_IFGR;
					error_code  <= ERR_NONE;
					last        <= 1'b1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/bnm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bnm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire bnm_pkg::sts_t sts,
	output bnm_pkg::cmd_t      cmd
);
	import bnm_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EVAL  = 2'd1;
	localparam logic [1:0] S_SCOPE = 2'd2;
	localparam logic [1:0] S_SWAIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d        = state_q;
		cmd.latch_in   = 1'b0;
		cmd.emit       = 1'b0;
		cmd.emit_kind  = K_ACC;
		cmd.commit     = 1'b0;
		cmd.scope_pop  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.ignore) begin
					state_d = S_IDLE;
				end else if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					if (sts.err != ERR_NONE) begin
						cmd.emit_kind = K_ERR;
						state_d       = S_IDLE;
					end else if (sts.is_closer) begin
						cmd.emit_kind = K_PATCH;
						state_d       = S_SCOPE;
					end else begin
						cmd.commit = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			S_SCOPE: begin
				if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					if (sts.scope_more) begin
						cmd.emit_kind = K_SCOPE;
						cmd.scope_pop = 1'b1;
						state_d       = S_SWAIT;
					end else begin
						cmd.commit = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			S_SWAIT: begin
				state_d = S_SCOPE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/block_nesting_matcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Matches block openers and closers in a stream of decoded statements and
// gives one beat per result: backpatch, scope records, then the accepted or
// error beat marked last. A new statement is taken only when the last is
// done. Each scope record is followed by a wait state, since each popped
// scope entry is read again from the scope stack memory through its
// registered read port. Unknown actions give no beat.
module block_nesting_matcher_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         action,
	input  wire logic               operand_ok,
	input  wire logic [5:0]         target_var,
	input  wire logic               has_count,
	input  wire logic signed [31:0] const_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              kind,
	output logic [11:0]             first_pos,
	output logic [12:0]             second_pos,
	output logic [1:0]              opener_kind,
	output logic [2:0]              error_code,
	output logic                    last
);
	import bnm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bnm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bnm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.operand_ok  (operand_ok),
		.target_var  (target_var),
		.has_count   (has_count),
		.const_value (const_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.first_pos   (first_pos),
		.second_pos  (second_pos),
		.opener_kind (opener_kind),
		.error_code  (error_code),
		.last        (last)
	);

endmodule
`default_nettype wire
